// ----- src/sapq_pkg.sv -----
package sapq_pkg;

    localparam int DEPTH = 8;
    localparam int VALUE_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENTRY_COUNT_W = 4;
    localparam int STATUS_W = 2;
    localparam int OUT_FIELDS_W = STATUS_W + ENTRY_COUNT_W + VALUE_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Flags that travel from a cell to its right neighbor.
    typedef struct packed
    {
        logic gt;    // this entry is larger than the operand
        logic seen;  // a match was found at this cell or to its left
    } link_t;

endpackage

// ----- src/sapq_cell.sv -----
module sapq_cell
(
    input  logic                                 clk,
    input  sapq_pkg::cmd_t                       cmd,
    input  logic signed [sapq_pkg::VALUE_W-1:0] value,
    input  logic                                 occ,
    input  logic                                 load,
    input  sapq_pkg::link_t                      left_link,
    input  logic signed [sapq_pkg::VALUE_W-1:0] left_val,
    input  logic signed [sapq_pkg::VALUE_W-1:0] right_val,
    output sapq_pkg::link_t                      right_link,
    output logic signed [sapq_pkg::VALUE_W-1:0] cur_val,
    output logic signed [sapq_pkg::VALUE_W-1:0] next_val
);

    logic signed [sapq_pkg::VALUE_W-1:0] val_reg;
    logic signed [sapq_pkg::VALUE_W-1:0] val_next;
    logic                                 gt;
    logic                                 eq;

    always_comb
    begin
        gt = occ && (val_reg > value);
        eq = occ && (val_reg == value);
        right_link.gt = gt;
        right_link.seen = left_link.seen | eq;
        case (cmd)
            sapq_pkg::CMD_INSERT:
            begin
                // The array is sorted, so the larger entries form a prefix.
                if (gt)
                begin
                    val_next = val_reg;
                end
                else if (left_link.gt)
                begin
                    val_next = value;
                end
                else if (occ || left_link.gt)
                begin
                    val_next = left_val;
                end
                else
                begin
                    val_next = left_val;
                end
            end
            sapq_pkg::CMD_DELETE:
            begin
                val_next = right_link.seen ? right_val : val_reg;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
        end
    end

    assign cur_val = val_reg;
    assign next_val = val_next;

endmodule

// ----- src/sorted_array_priority_queue_unit.sv -----
// Sorted priority queue built as a row of compare-and-shift cells.
// The result of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle; every cell compares against the operand in
// parallel, and only the output register holds an item back while it waits.
// Reset clears the entry count and the output valid; stored values need none.
module sorted_array_priority_queue_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sapq_pkg::VALUE_W-1:0]      s_axis_tdata,   // value[31:0]
    input  logic                              s_axis_tuser,   // cmd[0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[1:0], entry_count[5:2], head_value[37:6], zero pad[39:38]
    output logic [sapq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int DEPTH = sapq_pkg::DEPTH;
    localparam int CNT_W = sapq_pkg::CNT_W;
    localparam int VALUE_W = sapq_pkg::VALUE_W;

    logic                        in_acc;
    sapq_pkg::cmd_t              cmd;
    logic signed [VALUE_W-1:0]   value;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    sapq_pkg::status_t           status;
    logic                        load;
    logic signed [VALUE_W-1:0]   head_next;

    logic                        out_valid_reg;
    logic [sapq_pkg::OUT_DATA_W-1:0] out_data_reg;

    sapq_pkg::link_t             links [DEPTH+1];
    logic signed [VALUE_W-1:0]   cur_vals [DEPTH];
    logic signed [VALUE_W-1:0]   next_vals [DEPTH];

    assign cmd = sapq_pkg::cmd_t'(s_axis_tuser);
    assign value = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign links[0] = '{gt: 1'b0, seen: 1'b0};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_val;
        logic signed [VALUE_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = value;
        end
        else
        begin : g_mid
            assign left_val = cur_vals[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = cur_vals[i];
        end
        else
        begin : g_inner
            assign right_val = cur_vals[i+1];
        end

        sapq_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .value      (value),
            .occ        (count_reg > CNT_W'(i)),
            .load       (load),
            .left_link  (links[i]),
            .left_val   (left_val),
            .right_val  (right_val),
            .right_link (links[i+1]),
            .cur_val    (cur_vals[i]),
            .next_val   (next_vals[i])
        );
    end

    always_comb
    begin
        case (cmd)
            sapq_pkg::CMD_INSERT:
            begin
                status = (count_reg == CNT_W'(DEPTH)) ? sapq_pkg::ST_OVERFLOW
                                                       : sapq_pkg::ST_DONE;
            end
            sapq_pkg::CMD_DELETE:
            begin
                if (count_reg == '0)
                begin
                    status = sapq_pkg::ST_EMPTY;
                end
                else if (!links[DEPTH].seen)
                begin
                    status = sapq_pkg::ST_NOTFOUND;
                end
                else
                begin
                    status = sapq_pkg::ST_DONE;
                end
            end
            default:
            begin
                status = sapq_pkg::ST_DONE;
            end
        endcase

        load = in_acc && (status == sapq_pkg::ST_DONE);

        count_next = count_reg;
        if (load)
        begin
            count_next = (cmd == sapq_pkg::CMD_INSERT) ? count_reg + 1'b1
                                                         : count_reg - 1'b1;
        end

        if (count_next == '0)
        begin
            head_next = '0;
        end
        else
        begin
            head_next = load ? next_vals[0] : cur_vals[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= sapq_pkg::OUT_DATA_W'({head_next,
                                                   sapq_pkg::ENTRY_COUNT_W'(count_next),
                                                   status});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(count_reg))
        else $error("entry count changed without an item");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd == sapq_pkg::CMD_INSERT && count_reg == CNT_W'(DEPTH))
        |=> (m_axis_tdata[sapq_pkg::STATUS_W-1:0] == sapq_pkg::ST_OVERFLOW)
            && (count_reg == CNT_W'(DEPTH)))
        else $error("insert into full store not refused");

    a_delete_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd == sapq_pkg::CMD_DELETE && status == sapq_pkg::ST_DONE)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not reduce the entry count");

endmodule
